// ===== rtl/ifrt_pkg.sv =====
// Shared types and constants for the IPv4 fragment reassembly tracker.
// Depends on nothing; imported by the slot memory and the tracker.
package ifrt_pkg;

  localparam logic [2:0] KIND_DELIVER = 3'd0;
  localparam logic [2:0] KIND_MALFORM = 3'd1;
  localparam logic [2:0] KIND_STORED  = 3'd2;
  localparam logic [2:0] KIND_PIECE   = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;
  localparam logic [2:0] KIND_EXPIRED = 3'd5;

  localparam logic       OP_HEADER = 1'b0;
  localparam logic       OP_TICK   = 1'b1;

  localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
  localparam logic [3:0]  ACCEPTED_VERSION = 4'd4;
  localparam logic [7:0]  TIMEOUT_AT_RESET = 8'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] captured_length;
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic        more_fragments;
    logic [12:0] frag_offset;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } ifrt_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  out_protocol;
    logic [15:0] merged_length;
    logic        last;
  } ifrt_out_t;

  // One stored fragment: key, addresses, offset, flag, lengths, lifetime.
  typedef struct packed {
    logic [23:0] key;
    logic [31:0] src;
    logic [31:0] dst;
    logic [12:0] off;
    logic        more;
    logic [15:0] total;
    logic [3:0]  hwords;
    logic [7:0]  timer;
  } ifrt_entry_t;

  function automatic logic [15:0] data_len(input ifrt_entry_t e);
    data_len = e.total - {10'd0, e.hwords, 2'b00};
  endfunction

endpackage

// ===== rtl/ifrt_slot_mem.sv =====
// Slot entry memory: one write port, one registered read port.
// Depends on ifrt_pkg.
module ifrt_slot_mem
  import ifrt_pkg::*;
#(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned AW    = 4
) (
  input  logic         clk_i,
  input  logic         we_i,
  input  logic [AW-1:0] waddr_i,
  input  ifrt_entry_t  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output ifrt_entry_t  rdata_o
);

  ifrt_entry_t mem_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ifrt_order_mem.sv =====
// Arrival order list memory: one write port, one registered read port.
// Depends on nothing but its parameters.
module ifrt_order_mem #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ip_fragment_reassembly_tracker.sv =====
// IPv4 fragment reassembly tracker: slot memory plus sequencer.
// A dropped or delivered header gives its result the cycle after acceptance; a stored
// fragment walks the arrival list for a head at offset zero and its linked pieces, then
// emits the pieces of a complete chain and compacts, else reports itself stored; a tick
// reads each occupied slot, decrements its timer and compacts. Throughput: one item at a
// time, busy is high while it is worked (a stored or dropped result shows once busy is low);
// the receiver cannot stall. Reset clears valid bits, occupancy and timeout (to 3).
module ip_fragment_reassembly_tracker
  import ifrt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ifrt_in_t  in_data_i,
  output logic      out_valid_o,
  output ifrt_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_FREE  = 15'h0002,
    S_HEADR = 15'h0004,   // wait head order read
    S_HEADE = 15'h0008,   // wait head entry read
    S_HEADC = 15'h0010,
    S_SRCHO = 15'h0020,   // wait candidate order read
    S_SRCHE = 15'h0040,   // wait candidate entry read
    S_SRCHC = 15'h0080,
    S_EMIT  = 15'h0100,   // wait chain entry read
    S_EMITC = 15'h0200,
    S_CMPO  = 15'h0400,   // compaction: read order
    S_CMPW  = 15'h0800,
    S_TICKO = 15'h1000,
    S_TICKE = 15'h2000,
    S_TICKC = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]    timeout_q;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0] occ_q, occ_d;
  ifrt_in_t      in_q, in_d;
  logic [AW-1:0] ns_q, ns_d;
  logic [CW-1:0] h_q, h_d, j_q, j_d, len_q, len_d, p_q, p_d, n_q, n_d;
  logic [AW-1:0] head_q, head_d;
  ifrt_entry_t   hent_q, hent_d;
  logic [15:0]   nxt_q, nxt_d, merged_q, merged_d;
  logic [SLOTS-1:0] used_q, used_d;
  logic [AW-1:0] chain_q [SLOTS];
  logic          chain_we;
  logic [AW-1:0] chain_wa, chain_wd;
  logic          tick_q, tick_d;
  logic [AW-1:0] cur_q, cur_d;

  // memory ports
  logic          sm_we;
  logic [AW-1:0] sm_wa, sm_ra;
  ifrt_entry_t   sm_wd, sm_rd;
  logic          om_we;
  logic [AW-1:0] om_wa, om_wd, om_ra, om_rd;

  ifrt_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_slot_mem (
    .clk_i, .we_i(sm_we), .waddr_i(sm_wa), .wdata_i(sm_wd),
    .raddr_i(sm_ra), .rdata_o(sm_rd)
  );

  ifrt_order_mem #(.SLOTS(SLOTS), .AW(AW)) u_order_mem (
    .clk_i, .we_i(om_we), .waddr_i(om_wa), .wdata_i(om_wd),
    .raddr_i(om_ra), .rdata_o(om_rd)
  );

  logic          ov_d;
  ifrt_out_t     od_d;
  logic [AW-1:0] chain_rd;
  logic          cand_ok;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign chain_rd    = chain_q[p_q[AW-1:0]];

  assign cand_ok = ({sm_rd.off[12:0], 3'b000} == nxt_q) && (sm_rd.key == hent_q.key)
                   && (sm_rd.src == hent_q.src) && (sm_rd.dst == hent_q.dst);

  always_comb begin
    state_d = state_q; valid_d = valid_q; occ_d = occ_q; in_d = in_q; ns_d = ns_q;
    h_d = h_q; j_d = j_q; len_d = len_q; p_d = p_q; n_d = n_q; head_d = head_q;
    hent_d = hent_q; nxt_d = nxt_q; merged_d = merged_q; used_d = used_q;
    tick_d = tick_q; cur_d = cur_q;
    sm_we = 1'b0; sm_wa = ns_q; sm_wd = '0; sm_ra = '0;
    om_we = 1'b0; om_wa = '0; om_wd = '0; om_ra = '0;
    chain_we = 1'b0; chain_wa = '0; chain_wd = '0;
    ov_d = 1'b0; od_d = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          in_d = in_data_i;
          tick_d = 1'b0;
          if (in_data_i.op == OP_TICK) begin
            tick_d = 1'b1;
            h_d = '0;
            state_d = (occ_q == '0) ? S_IDLE : S_TICKO;
            om_ra = '0;
          end else if (in_data_i.captured_length < MIN_HEADER_BYTES ||
                       in_data_i.version != ACCEPTED_VERSION) begin
            ov_d = 1'b1; od_d.kind = KIND_MALFORM; od_d.last = 1'b1;
          end else if (in_data_i.frag_offset == '0 && !in_data_i.more_fragments) begin
            ov_d = 1'b1; od_d.kind = KIND_DELIVER; od_d.last = 1'b1;
            od_d.out_protocol = in_data_i.protocol;
            od_d.merged_length = in_data_i.total_length;
          end else if (occ_q >= SLOTS_C) begin
            ov_d = 1'b1; od_d.kind = KIND_FULL; od_d.last = 1'b1;
          end else begin
            tick_d = 1'b0;
            state_d = S_FREE;
          end
        end
      end
      S_FREE: begin
        // first free slot by priority
        ns_d = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
          if (!valid_q[k]) ns_d = AW'(k);
        end
        sm_we = 1'b1; sm_wa = ns_d;
        sm_wd.key = {in_q.ident, in_q.protocol};
        sm_wd.src = in_q.src_addr; sm_wd.dst = in_q.dst_addr;
        sm_wd.off = in_q.frag_offset; sm_wd.more = in_q.more_fragments;
        sm_wd.total = in_q.total_length; sm_wd.hwords = in_q.header_words;
        sm_wd.timer = timeout_q;
        valid_d[ns_d] = 1'b1;
        om_we = 1'b1; om_wa = occ_q[AW-1:0]; om_wd = ns_d;
        occ_d = occ_q + 1'b1;
        h_d = '0;
        state_d = S_HEADR;
      end
      S_HEADR: begin
        if (h_q >= occ_q) begin
          ov_d = 1'b1; od_d.kind = KIND_STORED; od_d.slot = 4'(ns_q);
          od_d.last = 1'b1;
          state_d = S_IDLE;
        end else begin
          om_ra = h_q[AW-1:0];
          state_d = S_HEADE;
        end
      end
      S_HEADE: begin
        head_d = om_rd; sm_ra = om_rd;
        state_d = S_HEADC;
      end
      S_HEADC: begin
        hent_d = sm_rd;
        if (sm_rd.off != '0) begin
          h_d = h_q + 1'b1;
          state_d = S_HEADR;
        end else begin
          used_d = '0; used_d[head_q] = 1'b1;
          chain_we = 1'b1; chain_wa = '0; chain_wd = head_q;
          len_d = CW'(1);
          nxt_d = data_len(sm_rd);
          j_d = '0;
          state_d = (SLOTS_C > CW'(1)) ? S_SRCHO : S_HEADR;
          if (SLOTS_C <= CW'(1)) h_d = h_q + 1'b1;
        end
      end
      S_SRCHO: begin
        if (j_q >= occ_q) begin
          // no link found: next head
          h_d = h_q + 1'b1;
          state_d = S_HEADR;
        end else begin
          om_ra = j_q[AW-1:0];
          state_d = S_SRCHE;
        end
      end
      S_SRCHE: begin
        cur_d = om_rd; sm_ra = om_rd;
        if (used_q[om_rd]) begin
          j_d = j_q + 1'b1;
          state_d = S_SRCHO;
        end else begin
          state_d = S_SRCHC;
        end
      end
      S_SRCHC: begin
        if (cand_ok) begin
          chain_we = 1'b1; chain_wa = len_q[AW-1:0]; chain_wd = cur_q;
          used_d[cur_q] = 1'b1;
          len_d = len_q + 1'b1;
          nxt_d = nxt_q + data_len(sm_rd);
          j_d = '0;
          if (!sm_rd.more) begin
            p_d = '0;
            state_d = S_EMIT;
          end else if (len_q + 1'b1 >= SLOTS_C) begin
            h_d = h_q + 1'b1;
            state_d = S_HEADR;
          end else begin
            state_d = S_SRCHO;
          end
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_SRCHO;
        end
      end
      S_EMIT: begin
        sm_ra = chain_rd;
        state_d = S_EMITC;
      end
      S_EMITC: begin
        if (p_q == '0) merged_d = sm_rd.total;
        else merged_d = merged_q + data_len(sm_rd);
        ov_d = 1'b1; od_d.kind = KIND_PIECE; od_d.slot = 4'(chain_rd);
        od_d.out_protocol = hent_q.key[7:0]; od_d.merged_length = merged_d;
        od_d.last = (p_q + 1'b1 == len_q);
        valid_d[chain_rd] = 1'b0;
        p_d = p_q + 1'b1;
        if (p_q + 1'b1 == len_q) begin
          h_d = '0; n_d = '0;
          state_d = S_CMPO;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CMPO: begin
        if (h_q >= occ_q) begin
          occ_d = n_q;
          state_d = S_IDLE;
        end else begin
          om_ra = h_q[AW-1:0];
          state_d = S_CMPW;
        end
      end
      S_CMPW: begin
        if (valid_q[om_rd]) begin
          om_we = 1'b1; om_wa = n_q[AW-1:0]; om_wd = om_rd;
          n_d = n_q + 1'b1;
        end
        h_d = h_q + 1'b1;
        state_d = S_CMPO;
      end
      S_TICKO: begin
        om_ra = h_q[AW-1:0];
        state_d = S_TICKE;
      end
      S_TICKE: begin
        cur_d = om_rd; sm_ra = om_rd;
        state_d = S_TICKC;
      end
      S_TICKC: begin
        sm_we = 1'b1; sm_wa = cur_q; sm_wd = sm_rd;
        sm_wd.timer = sm_rd.timer - 8'd1;
        if (sm_wd.timer == 8'd0) begin
          valid_d[cur_q] = 1'b0;
          ov_d = 1'b1; od_d.kind = KIND_EXPIRED; od_d.slot = 4'(cur_q);
        end
        h_d = h_q + 1'b1;
        if (h_q + 1'b1 >= occ_q) begin
          h_d = '0; n_d = '0;
          state_d = S_CMPO;
        end else begin
          state_d = S_TICKO;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Tick results: last marks the final expiry, known only after the sweep;
  // hold each expiry one slot and release it when the next one or the end shows.
  logic      pend_q, pend_d;
  ifrt_out_t pendo_q, pendo_d;
  logic      ov_q;
  ifrt_out_t od_q;
  logic      tick_end;

  assign tick_end = tick_q && (state_q == S_CMPO) && (state_d == S_IDLE);

  always_comb begin
    pend_d = pend_q; pendo_d = pendo_q;
    out_valid_o = ov_q; out_data_o = od_q;
    if (tick_q && ov_q) begin
      out_valid_o = pend_q; out_data_o = pendo_q;
      pend_d = 1'b1; pendo_d = od_q;
    end else if (tick_q && pend_q && tick_end) begin
      out_valid_o = 1'b1; out_data_o = pendo_q; out_data_o.last = 1'b1;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_q <= '0; occ_q <= '0; timeout_q <= TIMEOUT_AT_RESET;
      ov_q <= 1'b0; pend_q <= 1'b0; tick_q <= 1'b0;
    end else begin
      state_q <= state_d; valid_q <= valid_d; occ_q <= occ_d;
      ov_q <= ov_d; pend_q <= pend_d; tick_q <= tick_d;
      if (cfg_valid_i && cfg_ready_o) timeout_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d; ns_q <= ns_d; h_q <= h_d; j_q <= j_d; len_q <= len_d;
    p_q <= p_d; n_q <= n_d; head_q <= head_d; hent_q <= hent_d; nxt_q <= nxt_d;
    merged_q <= merged_d; used_q <= used_d; cur_q <= cur_d; od_q <= od_d;
    pendo_q <= pendo_d;
    if (chain_we) chain_q[chain_wa] <= chain_wd;
  end

  // The tick path ends in a final compaction; after any compaction, occupancy stays within the slot count.
  a_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMPO && state_d == S_IDLE) |=> (occ_q <= SLOTS_C))
    else $error("occupancy beyond slot count");
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q <= SLOTS_C)) else $error("occupancy overflow");
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !tick_q) |-> !pend_q) else $error("stale held result");

endmodule
